// ----- design/slmrs_pkg.sv -----
`timescale 1ns / 1ps

package slmrs_pkg;

  localparam int GLYPH_COUNT_DEF = 32;
  localparam int CHAR_SLOTS_DEF  = 5;
  localparam int SCAN_ROWS_DEF   = 8;

  localparam int GLYPH_BYTES_LOG2 = 5;

  localparam logic [7:0] SHIFT_PERIOD_RST = 8'd40;
  localparam logic [4:0] LAST_START_RST   = 5'd11;

  localparam logic MODE_WRITE = 1'b1;

  localparam logic REG_SHIFT_PERIOD = 1'b0;
  localparam logic REG_LAST_START   = 1'b1;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_INIT   = 4'd0;
  localparam logic [STEP_W-1:0] ST_REDUCE = 4'd1;
  localparam logic [STEP_W-1:0] ST_RD_A1  = 4'd2;
  localparam logic [STEP_W-1:0] ST_RD_B1  = 4'd3;
  localparam logic [STEP_W-1:0] ST_RD_A2  = 4'd4;
  localparam logic [STEP_W-1:0] ST_RD_B2  = 4'd5;
  localparam logic [STEP_W-1:0] ST_WAIT   = 4'd6;
  localparam logic [STEP_W-1:0] ST_EMIT1  = 4'd7;
  localparam logic [STEP_W-1:0] ST_EMIT2  = 4'd8;
  localparam logic [STEP_W-1:0] ST_ADV    = 4'd9;

  typedef enum logic [1:0] {
    SEL_A1,
    SEL_B1,
    SEL_A2,
    SEL_B2
  } byte_sel_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INIT,
    OP_NEXT_SLOT,
    OP_ADVANCE
  } op_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_REDUCE,
    JMP_SLOT,
    JMP_DONE
  } jmp_e;

  typedef struct packed {
    logic              rd_en;
    byte_sel_e         rd_sel;
    logic              emit_en;
    logic              emit_hi;
    op_e               op;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // control store: one word per step
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t cw;
    cw = '{rd_en: 1'b0, rd_sel: SEL_A1, emit_en: 1'b0, emit_hi: 1'b0,
           op: OP_NONE, jmp: JMP_NEXT, target: ST_INIT};
    unique case (step)
      ST_INIT: begin
        cw.op = OP_INIT;
      end
      ST_REDUCE: begin
        cw.jmp = JMP_REDUCE;
      end
      ST_RD_A1: begin
        cw.rd_en  = 1'b1;
        cw.rd_sel = SEL_A1;
      end
      ST_RD_B1: begin
        cw.rd_en  = 1'b1;
        cw.rd_sel = SEL_B1;
      end
      ST_RD_A2: begin
        cw.rd_en  = 1'b1;
        cw.rd_sel = SEL_A2;
      end
      ST_RD_B2: begin
        cw.rd_en  = 1'b1;
        cw.rd_sel = SEL_B2;
      end
      ST_WAIT: begin
        cw.op = OP_NONE;
      end
      ST_EMIT1: begin
        cw.emit_en = 1'b1;
      end
      ST_EMIT2: begin
        cw.emit_en = 1'b1;
        cw.emit_hi = 1'b1;
        cw.op      = OP_NEXT_SLOT;
        cw.jmp     = JMP_SLOT;
        cw.target  = ST_RD_A1;
      end
      ST_ADV: begin
        cw.op  = OP_ADVANCE;
        cw.jmp = JMP_DONE;
      end
      default: begin
        cw.jmp = JMP_DONE;
      end
    endcase
    return cw;
  endfunction

  // top byte of {hi, lo} shifted left, inverted for the column drivers
  function automatic logic [7:0] merge_byte(input logic [7:0] hi, input logic [7:0] lo,
                                            input logic [2:0] s);
    logic [15:0] w;
    w = {hi, lo} << s;
    return ~w[15:8];
  endfunction

endpackage

// ----- design/scrolling_led_matrix_row_scanner_core.sv -----
`timescale 1ns / 1ps

// Row scanner for a multiplexed LED matrix showing scrolling 16x16 glyphs.
// Input channel (in_valid_i / in_ready_o): mode_i = 1 writes font_data_i into
// the glyph memory at font_addr_i (addresses past the memory are dropped) and
// gives no result. mode_i = 0 is a display tick: it scans the current row
// and delivers 2*CHAR_SLOTS pairs on the output channel (out_valid_o /
// out_ready_i), the last one with latch_o set, then advances row and divider,
// and on a divider wrap also the bit shift, phase and start glyph.
// One item is worked on at a time. A tick runs a microcoded sequence: two
// setup steps (plus one per wrap of the glyph index), then per slot four
// glyph memory reads on its single port, one wait and two emit steps, then
// one update step. Results leave through an output register; when the
// receiver stalls, the sequencer holds in its emit step and the input stays
// not ready.
// The config port (cfg_we_i) must be written only while the block is idle;
// the block itself does not enforce this.
// Reset clears the counters, the carry rows and the config registers to
// their defaults; the glyph memory is not cleared and must be loaded first.
module scrolling_led_matrix_row_scanner_core #(
  parameter int GLYPH_COUNT = slmrs_pkg::GLYPH_COUNT_DEF,
  parameter int CHAR_SLOTS  = slmrs_pkg::CHAR_SLOTS_DEF,
  parameter int SCAN_ROWS   = slmrs_pkg::SCAN_ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       mode_i,
  input  logic [9:0] font_addr_i,
  input  logic [7:0] font_data_i,

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] row_select_o,
  output logic [7:0] upper_serial_byte_o,
  output logic [7:0] lower_serial_byte_o,
  output logic       latch_o
);

  localparam int GW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int PW = (GW > 6) ? GW : 6;
  localparam int AW = GW + slmrs_pkg::GLYPH_BYTES_LOG2;
  localparam int MEM_DEPTH = GLYPH_COUNT * 32;
  localparam int CW = ((AW > 10) ? AW : 10) + 1;
  localparam int RW = $clog2(SCAN_ROWS);
  localparam int SW = (CHAR_SLOTS > 1) ? $clog2(CHAR_SLOTS) : 1;

  localparam logic [PW:0]   GC_W     = (PW + 1)'(GLYPH_COUNT);
  localparam logic [PW-1:0] GC_P     = PW'(GLYPH_COUNT);
  localparam logic [PW-1:0] GC_LAST  = PW'(GLYPH_COUNT - 1);
  localparam logic [PW-1:0] SLOT_OFS = PW'(CHAR_SLOTS - 1);
  localparam logic [SW-1:0] SLOT_TOP = SW'(CHAR_SLOTS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(SCAN_ROWS - 1);

  // config registers
  logic [7:0] shift_period_q;
  logic [4:0] last_start_q;

  // display state
  logic [RW-1:0] row_q;
  logic [7:0]    div_q;
  logic [2:0]    bit_shift_q;
  logic          half_q;
  logic [4:0]    start_q;
  logic [7:0]    carry_up_q [SCAN_ROWS];
  logic [7:0]    carry_lo_q [SCAN_ROWS];

  // sequencer
  logic                         busy_q;
  logic [slmrs_pkg::STEP_W-1:0] step_q;
  logic [slmrs_pkg::STEP_W-1:0] step_d;
  slmrs_pkg::ucode_t            cw;
  logic [PW-1:0]                ptr_q;
  logic [SW-1:0]                slot_q;
  logic                         last_slot;
  logic                         ptr_high;
  logic                         step_go;

  // datapath
  logic [7:0]            mem_q [MEM_DEPTH];
  logic [7:0]            rdata_q;
  logic                  rd_pend_q;
  slmrs_pkg::byte_sel_e  rd_tag_q;
  logic [7:0]            a1_q, b1_q, a2_q, b2_q;
  logic [PW-1:0]         ptr_inc;
  logic [PW-1:0]         glyph_sel;
  logic [4:0]            col;
  logic [4:0]            ofs;
  logic [AW-1:0]         raddr;
  logic                  mem_we;
  logic                  rd_fire;
  logic                  tick_accept;

  // output register
  logic       out_valid_q;
  logic [2:0] row_out_q;
  logic [7:0] up_out_q, lo_out_q;
  logic       latch_q;
  logic       out_free;
  logic       load_out;
  logic [7:0] up_byte, lo_byte;

  // advance arithmetic
  logic [7:0] div_inc;
  logic [2:0] bs_inc;
  logic       half_nxt;
  logic [4:0] start_nxt;

  assign in_ready_o  = !busy_q;
  assign tick_accept = in_valid_i && in_ready_o && (mode_i != slmrs_pkg::MODE_WRITE);
  assign mem_we      = in_valid_i && in_ready_o && (mode_i == slmrs_pkg::MODE_WRITE) &&
                       (CW'(font_addr_i) < CW'(MEM_DEPTH));

  assign cw        = slmrs_pkg::ucode(step_q);
  assign last_slot = (slot_q == '0);
  assign ptr_high  = ({1'b0, ptr_q} >= GC_W);
  assign out_free  = !out_valid_q || out_ready_i;
  assign step_go   = busy_q && (!cw.emit_en || out_free);
  assign load_out  = step_go && cw.emit_en;
  assign rd_fire   = busy_q && cw.rd_en;

  // read address: whole glyph or the half between this glyph and the next
  assign ptr_inc = (ptr_q == GC_LAST) ? '0 : ptr_q + 1'b1;
  assign col     = 5'({row_q, 1'b0});

  always_comb begin
    glyph_sel = ptr_q;
    ofs       = col;
    unique case (cw.rd_sel)
      slmrs_pkg::SEL_A1: begin
        glyph_sel = half_q ? ptr_q : ptr_inc;
        ofs       = half_q ? col + 5'd1 : col;
      end
      slmrs_pkg::SEL_B1: begin
        glyph_sel = half_q ? ptr_q : ptr_inc;
        ofs       = half_q ? col + 5'd17 : col + 5'd16;
      end
      slmrs_pkg::SEL_A2: begin
        glyph_sel = ptr_q;
        ofs       = half_q ? col : col + 5'd1;
      end
      slmrs_pkg::SEL_B2: begin
        glyph_sel = ptr_q;
        ofs       = half_q ? col + 5'd16 : col + 5'd17;
      end
      default: begin
        glyph_sel = ptr_q;
        ofs       = col;
      end
    endcase
  end

  assign raddr = {glyph_sel[GW-1:0], ofs};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[AW'(font_addr_i)] <= font_data_i;
    end
    if (rd_fire) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // read data lands in rdata_q in the cycle after the read step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      rd_tag_q  <= slmrs_pkg::SEL_A1;
    end else begin
      rd_pend_q <= rd_fire;
      rd_tag_q  <= cw.rd_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      unique case (rd_tag_q)
        slmrs_pkg::SEL_A1: a1_q <= rdata_q;
        slmrs_pkg::SEL_B1: b1_q <= rdata_q;
        slmrs_pkg::SEL_A2: a2_q <= rdata_q;
        slmrs_pkg::SEL_B2: b2_q <= rdata_q;
        default:           a1_q <= rdata_q;
      endcase
    end
  end

  // pair merge
  always_comb begin
    if (cw.emit_hi) begin
      up_byte = slmrs_pkg::merge_byte(a2_q, a1_q, bit_shift_q);
      lo_byte = slmrs_pkg::merge_byte(b2_q, b1_q, bit_shift_q);
    end else begin
      up_byte = slmrs_pkg::merge_byte(a1_q, carry_up_q[row_q], bit_shift_q);
      lo_byte = slmrs_pkg::merge_byte(b1_q, carry_lo_q[row_q], bit_shift_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      row_out_q <= 3'(row_q);
      up_out_q  <= up_byte;
      lo_out_q  <= lo_byte;
      latch_q   <= cw.emit_hi && last_slot;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign row_select_o        = row_out_q;
  assign upper_serial_byte_o = up_out_q;
  assign lower_serial_byte_o = lo_out_q;
  assign latch_o             = latch_q;

  // next step
  always_comb begin
    step_d = step_q + 1'b1;
    unique case (cw.jmp)
      slmrs_pkg::JMP_NEXT:   step_d = step_q + 1'b1;
      slmrs_pkg::JMP_REDUCE: step_d = ptr_high ? step_q : step_q + 1'b1;
      slmrs_pkg::JMP_SLOT:   step_d = last_slot ? step_q + 1'b1 : cw.target;
      slmrs_pkg::JMP_DONE:   step_d = slmrs_pkg::ST_INIT;
      default:               step_d = slmrs_pkg::ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= slmrs_pkg::ST_INIT;
    end else if (tick_accept) begin
      busy_q <= 1'b1;
      step_q <= slmrs_pkg::ST_INIT;
    end else if (step_go) begin
      step_q <= step_d;
      if (cw.jmp == slmrs_pkg::JMP_DONE) begin
        busy_q <= 1'b0;
      end
    end
  end

  // glyph pointer and slot counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      slot_q <= '0;
    end else if (step_go) begin
      if (cw.op == slmrs_pkg::OP_INIT) begin
        ptr_q  <= PW'(start_q) + SLOT_OFS;
        slot_q <= SLOT_TOP;
      end else if (cw.jmp == slmrs_pkg::JMP_REDUCE && ptr_high) begin
        ptr_q <= ptr_q - GC_P;
      end else if (cw.op == slmrs_pkg::OP_NEXT_SLOT) begin
        ptr_q  <= (ptr_q == '0) ? GC_LAST : ptr_q - 1'b1;
        slot_q <= slot_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SCAN_ROWS; i++) begin
        carry_up_q[i] <= '0;
        carry_lo_q[i] <= '0;
      end
    end else if (step_go && cw.op == slmrs_pkg::OP_NEXT_SLOT) begin
      carry_up_q[row_q] <= a2_q;
      carry_lo_q[row_q] <= b2_q;
    end
  end

  // end-of-tick update
  assign div_inc   = div_q + 8'd1;
  assign bs_inc    = bit_shift_q + 3'd1;
  assign half_nxt  = (bs_inc == 3'd0) ? !half_q : half_q;
  assign start_nxt = ((bs_inc == 3'd0) && half_nxt) ? start_q + 5'd1 : start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      div_q       <= '0;
      bit_shift_q <= '0;
      half_q      <= 1'b0;
      start_q     <= '0;
    end else if (step_go && cw.op == slmrs_pkg::OP_ADVANCE) begin
      row_q <= (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
      if (div_inc > shift_period_q) begin
        div_q       <= '0;
        bit_shift_q <= bs_inc;
        half_q      <= half_nxt;
        start_q     <= (start_nxt > last_start_q) ? 5'd0 : start_nxt;
      end else begin
        div_q <= div_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_period_q <= slmrs_pkg::SHIFT_PERIOD_RST;
      last_start_q   <= slmrs_pkg::LAST_START_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slmrs_pkg::REG_SHIFT_PERIOD: shift_period_q <= cfg_wdata_i;
        slmrs_pkg::REG_LAST_START:   last_start_q   <= cfg_wdata_i[4:0];
        default:                     shift_period_q <= cfg_wdata_i;
      endcase
    end
  end

  // glyph pointer is reduced before the first read and in range at every read
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_fire |-> !ptr_high)
    else $error("glyph pointer out of range at read");

  // reads only come from an active tick
  a_rd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> busy_q)
    else $error("read data returned while idle");

  // the latched pair is followed by the update step
  a_latch_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && cw.emit_hi && last_slot) |=> (busy_q && step_q == slmrs_pkg::ST_ADV))
    else $error("latch pair not followed by update");

  // a tick starts the program at its first step
  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_accept |=> (busy_q && step_q == slmrs_pkg::ST_INIT))
    else $error("tick did not start the sequencer");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= ROW_LAST)
    else $error("row counter out of range");

endmodule
